// ===== hw/rtl/tpd_pkg.sv =====
// Shared constants and types for the triac phase dimmer.
// No dependencies; imported by every module of the block.
package tpd_pkg;

    localparam int RING_DEPTH_DEFAULT     = 10;
    localparam int LEVEL_COUNT_DEFAULT    = 100;
    localparam int CURVE_COUNT_DEFAULT    = 6;
    localparam int UNSYNCED_LIMIT_DEFAULT = 10;

    localparam logic [31:0] EARLY_US = 32'd19500;
    localparam int PERIOD_UNITS = 20000 / 256;
    localparam int HALF_UNITS   = 10000 / 256;
    localparam int TOL_UNITS    = 1000 / 256;
    localparam int MOD_SHIFT    = 22;
    localparam int MOD_RECIP    = (1 << MOD_SHIFT) / PERIOD_UNITS;

    localparam int MAINS_HALF_TICKS  = 20000;
    localparam int OFF_BEFORE_TICKS  = 4000;
    localparam int SHORT_PULSE_TICKS = 200;
    localparam logic [15:0] IDLE_COMPARE = 16'hFFFF;

    localparam logic [1:0] OP_ZERO_CROSS = 2'd0;
    localparam logic [1:0] OP_COMPARE    = 2'd1;
    localparam logic [1:0] OP_TABLE_LOAD = 2'd2;

    localparam logic [1:0] REG_TARGET_LEVEL = 2'd0;
    localparam logic [1:0] REG_MIN_LEVEL    = 2'd1;
    localparam logic [1:0] REG_CURVE_SELECT = 2'd2;
    localparam logic [1:0] REG_SHORT_PULSE  = 2'd3;

    typedef struct packed {
        logic        valid;
        logic        empty;
        logic        equal;
        logic [15:0] diff;
    } mod_req_t;

    typedef struct packed {
        logic done;
        logic agree;
    } scan_status_t;

endpackage

// ===== hw/rtl/tpd_mod_unit.sv =====
// Two-stage modulo-period unit: folds a pulse distance into one mains
// period and flags agreement. Depends on tpd_pkg.
module tpd_mod_unit
    import tpd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mod_req_t req,
    output logic     hit_valid,
    output logic     hit
);

    logic        s1_valid_reg;
    logic        s1_empty_reg;
    logic        s1_equal_reg;
    logic [15:0] s1_diff_reg;
    logic [9:0]  s1_quot_reg;
    logic [31:0] prod;
    logic [16:0] rem_raw;
    logic [16:0] rem;
    logic [16:0] off;
    logic        hit_next;
    logic        hit_valid_reg;
    logic        hit_reg;

    assign prod = {16'b0, req.diff} * 32'(MOD_RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= req.valid;
        end
        s1_empty_reg <= req.empty;
        s1_equal_reg <= req.equal;
        s1_diff_reg  <= req.diff;
        s1_quot_reg  <= prod[MOD_SHIFT +: 10];
    end

    // quotient is low by at most one
    always_comb begin
        rem_raw = {1'b0, s1_diff_reg} - 17'(s1_quot_reg * 17'(PERIOD_UNITS));
        rem     = (rem_raw >= 17'(PERIOD_UNITS)) ? rem_raw - 17'(PERIOD_UNITS) : rem_raw;
        off     = (rem >= 17'(HALF_UNITS)) ? 17'(PERIOD_UNITS) - rem : rem;
        hit_next = s1_empty_reg || (!s1_equal_reg && (off < 17'(TOL_UNITS)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_valid_reg <= 1'b0;
        end else begin
            hit_valid_reg <= s1_valid_reg;
        end
        hit_reg <= hit_next;
    end

    assign hit_valid = hit_valid_reg;
    assign hit       = hit_reg;

endmodule

// ===== hw/rtl/tpd_ring.sv =====
// Pulse ring with its scan sequencer: stores a pulse, walks the ring one
// entry per cycle through the modulo unit and counts agreeing entries.
// Depends on tpd_pkg and tpd_mod_unit.
module tpd_ring
    import tpd_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [15:0]  pulse,
    output scan_status_t status
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    logic [15:0]      ring_reg [RING_DEPTH];
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] idx_reg;
    logic             issue_reg;
    logic [15:0]      pulse_reg;
    logic [CNT_W-1:0] recv_reg;
    logic [CNT_W-1:0] hits_reg;
    logic [CNT_W-1:0] hits_next;
    logic             done_reg;
    logic             agree_reg;
    logic [15:0]      entry;
    mod_req_t         req;
    logic             hit_valid;
    logic             hit;

    assign entry = ring_reg[idx_reg];

    always_comb begin
        req.valid = issue_reg;
        req.empty = (entry == 16'd0);
        req.equal = (entry == pulse_reg);
        req.diff  = (pulse_reg > entry) ? pulse_reg - entry : entry - pulse_reg;
    end

    tpd_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .hit_valid (hit_valid),
        .hit       (hit)
    );

    assign hits_next = hits_reg + CNT_W'(hit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                ring_reg[i] <= 16'd0;
            end
            ptr_reg   <= '0;
            idx_reg   <= '0;
            issue_reg <= 1'b0;
            recv_reg  <= '0;
            hits_reg  <= '0;
            done_reg  <= 1'b0;
            agree_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                ring_reg[ptr_reg] <= pulse;
                ptr_reg   <= (ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                idx_reg   <= '0;
                issue_reg <= 1'b1;
                recv_reg  <= '0;
                hits_reg  <= '0;
            end else begin
                if (issue_reg) begin
                    if (idx_reg == PTR_W'(RING_DEPTH - 1)) begin
                        issue_reg <= 1'b0;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                if (hit_valid) begin
                    hits_reg <= hits_next;
                    recv_reg <= recv_reg + 1'b1;
                    if (recv_reg == CNT_W'(RING_DEPTH - 1)) begin
                        done_reg  <= 1'b1;
                        agree_reg <= (hits_next > CNT_W'(RING_DEPTH / 2));
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            pulse_reg <= pulse;
        end
    end

    always_comb begin
        status.done  = done_reg;
        status.agree = agree_reg;
    end

endmodule

// ===== hw/rtl/triac_phase_dimmer_unit.sv =====
// Triac phase dimmer top level: APB registers, sequencer, curve memory,
// gate phase state and output register. Depends on tpd_pkg and tpd_ring.
//
// Usage: items arrive on the s_ stream (zero cross, compare expiry or curve
// table load); every item yields exactly one result transfer on the m_
// stream. Registers are to be written through the APB port only while the
// block idles; the block itself does not enforce this. A compare expiry, a
// table load or an unused opcode goes from idle to the done state, which
// raises m_tvalid. A zero cross walks the pulse ring one entry per cycle
// through a two-stage modulo unit, then passes the evaluate state and, when
// it is accepted with a table lookup, the read and load states before the
// done state. One item is in work at a time; s_tready is high only while
// idle and rises with m_tvalid.
// The result waits in an output register; a stalled receiver holds the
// block before its next result, and s_tready returns after it is taken.
// Reset clears the ring, the phase sequence and the registers, and sets
// the firing delay to 0xFFFF. The curve memory is not cleared: a lookup
// of an entry never loaded returns an undefined delay.
module triac_phase_dimmer_unit
    import tpd_pkg::*;
#(
    parameter int RING_DEPTH     = RING_DEPTH_DEFAULT,
    parameter int LEVEL_COUNT    = LEVEL_COUNT_DEFAULT,
    parameter int CURVE_COUNT    = CURVE_COUNT_DEFAULT,
    parameter int UNSYNCED_LIMIT = UNSYNCED_LIMIT_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] operation, [33:2] time_us, [43:34] table_index, [59:44] table_value
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] accepted, [1] timer_reload, [17:2] compare_ticks, [18] triac_on,
    // [25:19] output_level
    output logic [31:0] m_tdata
);

    localparam int TABLE_SIZE = LEVEL_COUNT * CURVE_COUNT;
    localparam int TBL_AW     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int LAST_STEP  = 3 + 4 * UNSYNCED_LIMIT;
    localparam int PH_W       = $clog2(LAST_STEP + 1);

    localparam logic [15:0] CMP_LONG_BASE = 16'(MAINS_HALF_TICKS - OFF_BEFORE_TICKS);
    localparam logic [15:0] CMP_OFF_ADD   = 16'(OFF_BEFORE_TICKS);
    localparam logic [15:0] CMP_SHORT_ON  = 16'(SHORT_PULSE_TICKS);
    localparam logic [15:0] CMP_SHORT_OFF = 16'(MAINS_HALF_TICKS - SHORT_PULSE_TICKS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_LD   = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]  state_reg;
    logic [6:0]  target_reg;
    logic [6:0]  min_reg;
    logic [2:0]  curve_reg;
    logic        short_reg;

    logic [31:0] last_accept_reg;
    logic [31:0] time_reg;
    logic        early_ok_reg;
    logic [6:0]  ramp_reg;
    logic [15:0] fire_reg;
    logic [PH_W-1:0] phase_reg;
    logic        gate_reg;

    logic        res_acc_reg;
    logic        res_reload_reg;
    logic [15:0] res_cmp_reg;

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    logic [15:0] mem [TABLE_SIZE];
    logic [15:0] rd_data_reg;

    logic [1:0]  in_op;
    logic [31:0] in_time;
    logic [9:0]  in_index;
    logic [15:0] in_value;
    logic        in_xfer;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    logic [15:0] pulse_raw;
    logic [15:0] pulse;
    scan_status_t scan;

    logic [6:0]  tgt_max;
    logic [6:0]  tgt;
    logic [6:0]  ramp_next;
    logic [2:0]  curve_eff;
    logic [31:0] rd_addr_full;
    logic [31:0] wr_addr_full;
    logic        wr_en;
    logic [PH_W:0] phase_inc;
    logic        out_free;

    assign in_op    = s_tdata[1:0];
    assign in_time  = s_tdata[33:2];
    assign in_index = s_tdata[43:34];
    assign in_value = s_tdata[59:44];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            REG_TARGET_LEVEL: prdata = {25'b0, target_reg};
            REG_MIN_LEVEL:    prdata = {25'b0, min_reg};
            REG_CURVE_SELECT: prdata = {29'b0, curve_reg};
            REG_SHORT_PULSE:  prdata = {31'b0, short_reg};
            default:          prdata = 32'b0;
        endcase
    end

    assign pulse_raw = in_time[23:8];
    assign pulse     = (pulse_raw == 16'd0) ? 16'd1 : pulse_raw;

    tpd_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_xfer && (in_op == OP_ZERO_CROSS)),
        .pulse   (pulse),
        .status  (scan)
    );

    always_comb begin
        tgt_max = (target_reg > min_reg) ? target_reg : min_reg;
        tgt     = (9'(tgt_max) > 9'(LEVEL_COUNT)) ? 7'(LEVEL_COUNT) : tgt_max;
        if (ramp_reg < tgt) begin
            ramp_next = ramp_reg + 7'd1;
        end else if (ramp_reg > tgt) begin
            ramp_next = ramp_reg - 7'd1;
        end else begin
            ramp_next = ramp_reg;
        end
        curve_eff    = (32'(curve_reg) < 32'(CURVE_COUNT)) ? curve_reg : 3'd0;
        rd_addr_full = 32'(curve_eff) * 32'(LEVEL_COUNT) + 32'(ramp_reg) - 32'd1;
        wr_addr_full = 32'(in_index);
        wr_en        = in_xfer && (in_op == OP_TABLE_LOAD)
                       && (wr_addr_full < 32'(TABLE_SIZE));
        phase_inc    = {1'b0, phase_reg} + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr_full[TBL_AW-1:0]] <= in_value;
        end
        rd_data_reg <= mem[rd_addr_full[TBL_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= 7'd0;
            min_reg    <= 7'd0;
            curve_reg  <= 3'd0;
            short_reg  <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_TARGET_LEVEL: target_reg <= pwdata[6:0];
                REG_MIN_LEVEL:    min_reg    <= pwdata[6:0];
                REG_CURVE_SELECT: curve_reg  <= pwdata[2:0];
                REG_SHORT_PULSE:  short_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            time_reg     <= in_time;
            early_ok_reg <= ((in_time - last_accept_reg) >= EARLY_US);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            last_accept_reg <= 32'd0;
            ramp_reg        <= 7'd0;
            fire_reg        <= IDLE_COMPARE;
            phase_reg       <= '0;
            gate_reg        <= 1'b0;
            res_acc_reg     <= 1'b0;
            res_reload_reg  <= 1'b0;
            res_cmp_reg     <= 16'd0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        res_acc_reg    <= 1'b0;
                        res_reload_reg <= 1'b0;
                        res_cmp_reg    <= 16'd0;
                        state_reg      <= ST_DONE;
                        if (in_op == OP_ZERO_CROSS) begin
                            state_reg <= ST_SCAN;
                        end else if (in_op == OP_COMPARE) begin
                            res_reload_reg <= 1'b1;
                            if (phase_reg == '0) begin
                                gate_reg    <= 1'b0;
                                res_cmp_reg <= IDLE_COMPARE;
                            end else begin
                                if (phase_reg[0]) begin
                                    gate_reg    <= 1'b1;
                                    res_cmp_reg <= short_reg ? CMP_SHORT_ON
                                                             : CMP_LONG_BASE - fire_reg;
                                end else begin
                                    gate_reg    <= 1'b0;
                                    res_cmp_reg <= short_reg ? CMP_SHORT_OFF
                                                             : fire_reg + CMP_OFF_ADD;
                                end
                                phase_reg <= (phase_inc > (PH_W+1)'(LAST_STEP))
                                             ? '0 : phase_inc[PH_W-1:0];
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (scan.done) begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    state_reg <= ST_DONE;
                    if (early_ok_reg && scan.agree) begin
                        res_acc_reg     <= 1'b1;
                        res_reload_reg  <= 1'b1;
                        last_accept_reg <= time_reg;
                        ramp_reg        <= ramp_next;
                        if (ramp_next != 7'd0) begin
                            state_reg <= ST_RD;
                        end else begin
                            fire_reg    <= IDLE_COMPARE;
                            phase_reg   <= '0;
                            res_cmp_reg <= IDLE_COMPARE;
                        end
                    end
                end
                ST_RD: begin
                    state_reg <= ST_LD;
                end
                ST_LD: begin
                    fire_reg    <= rd_data_reg;
                    phase_reg   <= PH_W'(1);
                    res_cmp_reg <= rd_data_reg;
                    state_reg   <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            m_tdata_reg <= {6'b0, ramp_reg, gate_reg, res_cmp_reg,
                            res_reload_reg, res_acc_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== test/tb.sv =====
// Testbench for triac_phase_dimmer_unit: random stream traffic checked against an in-bench
// dimmer predictor, with APB register changes between idle phases.
// Depends on tpd_pkg and the triac_phase_dimmer_unit RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tpd_pkg::*;

    localparam int RING_N     = RING_DEPTH_DEFAULT;
    localparam int LEVELS     = LEVEL_COUNT_DEFAULT;
    localparam int CURVES     = CURVE_COUNT_DEFAULT;
    localparam int TABLE_N    = LEVELS * CURVES;
    localparam int LAST_PHASE = 3 + 4 * UNSYNCED_LIMIT_DEFAULT;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] table_value;
        logic [9:0]  table_index;
        logic [31:0] time_us;
        logic [1:0]  operation;
    } dimmer_item_t;

    typedef struct packed {
        logic [6:0]  output_level;
        logic        triac_on;
        logic [15:0] compare_ticks;
        logic        timer_reload;
        logic        accepted;
    } dimmer_result_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    always #5 aclk = ~aclk;

    triac_phase_dimmer_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    dimmer_item_t   pending_items[$];
    dimmer_result_t expected_results[$];
    dimmer_item_t   offered;
    int             mismatches = 0;
    bit             no_idle    = 1'b0;

    // predictor state
    logic [15:0] pulse_hist [RING_N] = '{default: '0};
    int          hist_ptr      = 0;
    logic [31:0] last_cross_us = '0;
    int          level_now     = 0;
    logic [15:0] delay_now     = IDLE_COMPARE;
    int          phase_now     = 0;
    logic        gate_now      = 1'b0;
    logic [15:0] delay_curve [TABLE_N] = '{default: '0};
    int          cfg_target = 0;
    int          cfg_min    = 0;
    int          cfg_curve  = 0;
    bit          cfg_short  = 1'b0;

    // stimulus bookkeeping: rows are loaded up to the highest level the ramp can reach
    int          gen_goal     = 0;
    int          gen_row      = 0;
    int          ramp_ceiling = 0;
    int          row_loaded [CURVES] = '{default: 0};
    logic [31:0] mains_us = '0;

    function automatic bit ring_agrees(logic [15:0] pulse);
        int hits, e, p, d, off;
        hits = 0;
        p = int'(pulse);
        for (int i = 0; i < RING_N; i++) begin
            e = int'(pulse_hist[i]);
            d = (p > e) ? p - e : e - p;
            off = d % PERIOD_UNITS;
            if (off >= HALF_UNITS) off = PERIOD_UNITS - off;
            if (e == 0) hits++;
            else if (e != p && off < TOL_UNITS) hits++;
        end
        return hits > RING_N / 2;
    endfunction

    function automatic dimmer_result_t predict_dimmer(dimmer_item_t it);
        dimmer_result_t r;
        logic [15:0] pulse;
        logic [31:0] since;
        logic [31:0] ticks;
        int goal, row;
        r = '0;
        case (it.operation)
            OP_ZERO_CROSS: begin
                pulse = it.time_us[23:8];
                if (pulse == 16'd0) pulse = 16'd1;
                pulse_hist[hist_ptr] = pulse;
                hist_ptr = (hist_ptr == RING_N - 1) ? 0 : hist_ptr + 1;
                since = it.time_us - last_cross_us;
                if (since >= EARLY_US && ring_agrees(pulse)) begin
                    goal = (cfg_target > cfg_min) ? cfg_target : cfg_min;
                    if (goal > LEVELS) goal = LEVELS;
                    row = (cfg_curve < CURVES) ? cfg_curve : 0;
                    last_cross_us = it.time_us;
                    if (level_now < goal) level_now++;
                    else if (level_now > goal) level_now--;
                    if (level_now != 0) begin
                        delay_now = delay_curve[row * LEVELS + level_now - 1];
                        phase_now = 1;
                    end else begin
                        delay_now = IDLE_COMPARE;
                        phase_now = 0;
                    end
                    r.accepted      = 1'b1;
                    r.timer_reload  = 1'b1;
                    r.compare_ticks = delay_now;
                end
            end
            OP_COMPARE: begin
                r.timer_reload = 1'b1;
                if (phase_now == 0) begin
                    gate_now = 1'b0;
                    r.compare_ticks = IDLE_COMPARE;
                end else begin
                    if (phase_now % 2 == 1) begin
                        gate_now = 1'b1;
                        ticks = cfg_short ? SHORT_PULSE_TICKS
                                          : MAINS_HALF_TICKS - OFF_BEFORE_TICKS - delay_now;
                    end else begin
                        gate_now = 1'b0;
                        ticks = cfg_short ? MAINS_HALF_TICKS - SHORT_PULSE_TICKS
                                          : delay_now + OFF_BEFORE_TICKS;
                    end
                    r.compare_ticks = ticks[15:0];
                    phase_now++;
                    if (phase_now > LAST_PHASE) phase_now = 0;
                end
            end
            OP_TABLE_LOAD: begin
                if (it.table_index < TABLE_N) delay_curve[it.table_index] = it.table_value;
            end
            default: ;
        endcase
        r.triac_on     = gate_now;
        r.output_level = level_now[6:0];
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) expected_results.push_back(predict_dimmer(offered));
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 12)) begin
                    offered = pending_items.pop_front();
                    s_tdata  <= {4'b0, offered};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        dimmer_result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[25:0];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected transfer, expected none, got %h", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(got.accepted));
                    check_field("timer_reload", 32'(want.timer_reload),
                                32'(got.timer_reload));
                    check_field("compare_ticks", 32'(want.compare_ticks),
                                32'(got.compare_ticks));
                    check_field("triac_on", 32'(want.triac_on), 32'(got.triac_on));
                    check_field("output_level", 32'(want.output_level),
                                32'(got.output_level));
                end
            end
            m_tready <= no_idle || $urandom_range(99) >= 12;
        end
    end

    task automatic push_item(logic [1:0] op, logic [31:0] t, logic [9:0] idx,
                             logic [15:0] val);
        dimmer_item_t it;
        it.operation   = op;
        it.time_us     = t;
        it.table_index = idx;
        it.table_value = val;
        pending_items.push_back(it);
    endtask

    function automatic logic [15:0] pick_delay();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 16'h0000;
        if (r < 20) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic load_row_to(int n);
        while (row_loaded[gen_row] < n) begin
            push_item(OP_TABLE_LOAD, $urandom, 10'(gen_row * LEVELS + row_loaded[gen_row]),
                      pick_delay());
            row_loaded[gen_row]++;
        end
    endtask

    task automatic push_cross(logic [31:0] t);
        if (ramp_ceiling < gen_goal) ramp_ceiling++;
        load_row_to(ramp_ceiling);
        push_item(OP_ZERO_CROSS, t, 10'($urandom), 16'($urandom));
    endtask

    task automatic push_compare();
        push_item(OP_COMPARE, $urandom, 10'($urandom), 16'($urandom));
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic reg_write(logic [1:0] idx, int val);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TARGET_LEVEL: cfg_target = val & 'h7F;
            REG_MIN_LEVEL:    cfg_min    = val & 'h7F;
            REG_CURVE_SELECT: cfg_curve  = val & 'h7;
            REG_SHORT_PULSE:  cfg_short  = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(int t, int m, int c, int s);
        wait_idle();
        reg_write(REG_TARGET_LEVEL, t);
        reg_write(REG_MIN_LEVEL, m);
        reg_write(REG_CURVE_SELECT, c);
        reg_write(REG_SHORT_PULSE, s);
        gen_goal = (t > m) ? t : m;
        if (gen_goal > LEVELS) gen_goal = LEVELS;
        gen_row = (c < CURVES) ? c : 0;
        load_row_to(ramp_ceiling);
    endtask

    task automatic run_traffic(int n, int max_cmp);
        int done, r, k;
        done = 0;
        while (done < n) begin
            r = $urandom_range(99);
            if (r < 82) begin
                mains_us += 32'd20000;
                push_cross(mains_us + $urandom_range(200));
                k = ($urandom_range(99) < 3) ? $urandom_range(LAST_PHASE + 3, LAST_PHASE - 3)
                                             : $urandom_range(max_cmp);
                repeat (k) push_compare();
                done += 1 + k;
            end else if (r < 86) begin
                push_cross(mains_us + $urandom_range(18000, 1000));
                done++;
            end else if (r < 89) begin
                push_cross($urandom);
                done++;
            end else if (r < 91) begin
                mains_us = $urandom;
            end else if (r < 95) begin
                push_item(OP_TABLE_LOAD, $urandom, 10'($urandom), 16'($urandom));
                done++;
            end else if (r < 97) begin
                push_item(OP_UNUSED, $urandom, 10'($urandom), 16'($urandom));
                done++;
            end else begin
                push_compare();
                done++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        push_item(OP_TABLE_LOAD, '0, 10'd0, 16'h0000);
        push_item(OP_TABLE_LOAD, '1, 10'd599, 16'hFFFF);
        push_item(OP_TABLE_LOAD, '0, 10'd600, 16'h1234);
        push_item(OP_TABLE_LOAD, '1, 10'd1023, 16'hFFFF);
        push_item(OP_UNUSED, '1, '1, '1);
        push_compare();
        push_item(OP_ZERO_CROSS, 32'h0000_0000, '0, '0);
        push_item(OP_ZERO_CROSS, 32'hFFFF_FFFF, '1, '1);
        push_compare();
        push_item(OP_ZERO_CROSS, 32'h0000_00FF, '0, '0);

        // mains train starts just below the counter wrap
        mains_us = 32'hFFFF_FFFF - 32'd100000;
        set_config(5, 0, 1, 0);
        run_traffic(25, 4);
        set_config(0, 9, 2, 1);
        run_traffic(25, 4);
        set_config(3, 3, 6, 0);
        run_traffic(25, 4);
        set_config(20, 0, 4, 1);
        no_idle = 1'b1;
        run_traffic(60, 4);
        wait_idle();
        no_idle = 1'b0;
        set_config(0, 0, 5, 0);
        run_traffic(25, 4);
        repeat (5) begin
            set_config($urandom_range(30), ($urandom_range(9) < 3) ? $urandom_range(30) : 0,
                       $urandom_range(7), $urandom_range(1));
            run_traffic(28, 4);
        end
        set_config(127, 0, 3, 0);
        run_traffic(65, 1);
        set_config(100, 100, 7, 1);
        run_traffic(55, 1);

        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== triac_phase_dimmer_unit.f =====
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_mod_unit.sv
hw/rtl/tpd_ring.sv
hw/rtl/triac_phase_dimmer_unit.sv
test/tb.sv
